// ===== sv/flac_frame_header_parser_core_assert.svh =====
// ----------------------------------------------------------------------------
// FLAC frame header parser assertion macros
// Shorthands for the concurrent checks, all clocked on clock and masked
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef FLAC_FRAME_HEADER_PARSER_CORE_ASSERT_SVH
`define FLAC_FRAME_HEADER_PARSER_CORE_ASSERT_SVH

// property must hold in every cycle out of reset
`define FFHP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// cond must hold in the cycle after trig
`define FFHP_ASSERT_NEXT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ===== sv/ffhp_pkg.sv =====
// ----------------------------------------------------------------------------
// FLAC frame header parser package
// Field widths, register indexes, status codes and code lookup tables.
// ----------------------------------------------------------------------------
package ffhp_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned SYNC_W   = 16;
   localparam int unsigned BLK_W    = 17;
   localparam int unsigned RATE_W   = 20;
   localparam int unsigned DEPTH_W  = 6;
   localparam int unsigned CHAN_W   = 4;
   localparam int unsigned INDEX_W  = 36;
   localparam int unsigned EXTRA_W  = 16;
   localparam int unsigned LEFT_W   = 3;

   localparam logic [RATE_W-1:0]  STREAM_RATE_RST  = RATE_W'(44100);
   localparam logic [DEPTH_W-1:0] STREAM_DEPTH_RST = DEPTH_W'(16);

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_STREAM_RATE  = 1'b0,
      CSR_STREAM_DEPTH = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_RESERVED_SIZE = 2'd1,
      STATUS_BAD_RATE      = 2'd2
   } status_type;

   // block size codes
   localparam logic [3:0] BSZ_RESERVED = 4'd0;
   localparam logic [3:0] BSZ_192      = 4'd1;
   localparam logic [3:0] BSZ_EXTRA8   = 4'd6;
   localparam logic [3:0] BSZ_EXTRA16  = 4'd7;

   // sample rate codes
   localparam logic [3:0] RATE_STREAM  = 4'd0;
   localparam logic [3:0] RATE_KHZ8    = 4'd12;
   localparam logic [3:0] RATE_HZ16    = 4'd13;
   localparam logic [3:0] RATE_DHZ16   = 4'd14;
   localparam logic [3:0] RATE_INVALID = 4'd15;

   localparam logic [2:0] DEPTH_STREAM = 3'd0;

   // fixed rates for codes 1..11
   function automatic logic [RATE_W-1:0] rate_from_code(input logic [3:0] code);
      logic [RATE_W-1:0] r;
      case (code)
         4'd1:    r = RATE_W'(88200);
         4'd2:    r = RATE_W'(176400);
         4'd3:    r = RATE_W'(192000);
         4'd4:    r = RATE_W'(8000);
         4'd5:    r = RATE_W'(16000);
         4'd6:    r = RATE_W'(22050);
         4'd7:    r = RATE_W'(24000);
         4'd8:    r = RATE_W'(32000);
         4'd9:    r = RATE_W'(44100);
         4'd10:   r = RATE_W'(48000);
         4'd11:   r = RATE_W'(96000);
         default: r = '0;
      endcase
      return r;
   endfunction

   // bits per sample for codes 1..7; code 3 is reserved and reads as 16
   function automatic logic [DEPTH_W-1:0] depth_from_code(input logic [2:0] code);
      logic [DEPTH_W-1:0] d;
      case (code)
         3'd1:    d = DEPTH_W'(8);
         3'd2:    d = DEPTH_W'(12);
         3'd3:    d = DEPTH_W'(16);
         3'd4:    d = DEPTH_W'(16);
         3'd5:    d = DEPTH_W'(20);
         3'd6:    d = DEPTH_W'(24);
         3'd7:    d = DEPTH_W'(28);
         default: d = '0;
      endcase
      return d;
   endfunction

endpackage

// ===== sv/flac_frame_header_parser_core.sv =====
// ----------------------------------------------------------------------------
// FLAC frame header parser core
// Walks a frame header one byte per word and returns the decoded header
// (block size, sample rate, depth, channel code, frame number, CRC byte)
// as one word once the CRC byte has been taken.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload                                  words
//   req_     in         header_byte, frame_start                 one per byte
//   rsp_     out        sync/size/rate/depth/chan/index/crc/stat one per header
//   csr_     in         index (0 rate, 1 depth), wdata           one per write
//
// - One header byte is taken per cycle while req_ready is high; a byte that
//   completes a header shows its result on rsp_ in the next cycle.
// - The result sits in a single output register; req_ready drops only while
//   that register is full and rsp_ready is low.
// - reset is synchronous; afterwards the parser waits for the first sync
//   byte and the stream settings return to 44100 Hz and 16 bits.
// - csr_ writes are always taken; csr_ready is tied high.
//
module flac_frame_header_parser_core (
   input  logic                                clock,
   input  logic                                reset,
   // header bytes
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ffhp_pkg::BYTE_W-1:0]         req_header_byte,
   input  logic                                req_frame_start,
   // decoded header
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ffhp_pkg::SYNC_W-1:0]         rsp_sync_code,
   output logic [ffhp_pkg::BLK_W-1:0]          rsp_block_length,
   output logic [ffhp_pkg::RATE_W-1:0]         rsp_rate_hz,
   output logic [ffhp_pkg::DEPTH_W-1:0]        rsp_sample_depth,
   output logic [ffhp_pkg::CHAN_W-1:0]         rsp_channel_code,
   output logic [ffhp_pkg::INDEX_W-1:0]        rsp_frame_index,
   output logic [ffhp_pkg::BYTE_W-1:0]         rsp_header_crc,
   output ffhp_pkg::status_type                rsp_status,
   // stream settings
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  ffhp_pkg::csr_index_type             csr_index,
   input  logic [ffhp_pkg::RATE_W-1:0]         csr_wdata
);

   import ffhp_pkg::*;

`include "flac_frame_header_parser_core_assert.svh"

   typedef enum logic [3:0] {
      PH_SYNC0,
      PH_SYNC1,
      PH_CODE_BYTE,
      PH_DEPTH,
      PH_NUM_FIRST,
      PH_NUM_CONT,
      PH_EXTRA_SIZE,
      PH_EXTRA_RATE,
      PH_CRC,
      PH_DONE
   } phase_type;

   // stream settings
   logic [RATE_W-1:0]  stream_rate_ff;
   logic [DEPTH_W-1:0] stream_depth_ff;

   // parse state
   phase_type           phase_ff, phase_in;
   logic [SYNC_W-1:0]   sync_acc_ff, sync_acc_in;
   logic [BYTE_W-1:0]   code_byte_ff, code_byte_in;
   logic [BYTE_W-1:0]   depth_byte_ff, depth_byte_in;
   logic [INDEX_W-1:0]  number_acc_ff, number_acc_in;
   logic [LEFT_W-1:0]   bytes_left_ff, bytes_left_in;
   logic [EXTRA_W-1:0]  extra_size_ff, extra_size_in;
   logic [EXTRA_W-1:0]  extra_rate_ff, extra_rate_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SYNC_W-1:0]   rsp_sync_ff;
   logic [BLK_W-1:0]    rsp_blk_ff, rsp_blk_in;
   logic [RATE_W-1:0]   rsp_rate_ff, rsp_rate_in;
   logic [DEPTH_W-1:0]  rsp_depth_ff, rsp_depth_in;
   logic [CHAN_W-1:0]   rsp_chan_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic [BYTE_W-1:0]   rsp_crc_ff;
   status_type          rsp_status_ff, rsp_status_in;

   logic                req_accept;
   logic                rsp_load;
   phase_type           cur_phase;
   logic [3:0]          size_code;
   logic [3:0]          rate_code;
   logic [2:0]          depth_code;
   phase_type           rate_phase, size_phase;
   logic [LEFT_W-1:0]   rate_left, size_left;
   logic [LEFT_W-1:0]   left_dec;
   logic                counted_phase;
   logic                size_has_extra;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   // frame_start forces a restart whatever the phase
   assign cur_phase  = req_frame_start ? PH_SYNC0 : phase_ff;
   assign rsp_load   = req_accept && (cur_phase == PH_CRC);

   assign size_code  = code_byte_ff[7:4];
   assign rate_code  = code_byte_ff[3:0];
   assign depth_code = depth_byte_ff[3:1];
   assign left_dec   = bytes_left_ff - LEFT_W'(1);

   // phase after the extra size bytes (or after the number if none)
   always_comb begin
      case (rate_code)
         RATE_KHZ8: begin
            rate_phase = PH_EXTRA_RATE;
            rate_left  = LEFT_W'(1);
         end
         RATE_HZ16, RATE_DHZ16: begin
            rate_phase = PH_EXTRA_RATE;
            rate_left  = LEFT_W'(2);
         end
         default: begin
            rate_phase = PH_CRC;
            rate_left  = '0;
         end
      endcase
   end

   // phase after the coded number
   always_comb begin
      case (size_code)
         BSZ_EXTRA8: begin
            size_phase = PH_EXTRA_SIZE;
            size_left  = LEFT_W'(1);
         end
         BSZ_EXTRA16: begin
            size_phase = PH_EXTRA_SIZE;
            size_left  = LEFT_W'(2);
         end
         default: begin
            size_phase = rate_phase;
            size_left  = rate_left;
         end
      endcase
   end

   // byte-by-byte parse
   always_comb begin
      phase_in      = phase_ff;
      sync_acc_in   = sync_acc_ff;
      code_byte_in  = code_byte_ff;
      depth_byte_in = depth_byte_ff;
      number_acc_in = number_acc_ff;
      bytes_left_in = bytes_left_ff;
      extra_size_in = extra_size_ff;
      extra_rate_in = extra_rate_ff;
      if (req_accept) begin
         case (cur_phase)
            PH_SYNC0: begin
               // new frame: clear what the previous one left behind
               sync_acc_in   = {req_header_byte, 8'h00};
               code_byte_in  = '0;
               depth_byte_in = '0;
               number_acc_in = '0;
               bytes_left_in = '0;
               extra_size_in = '0;
               extra_rate_in = '0;
               phase_in      = PH_SYNC1;
            end
            PH_SYNC1: begin
               sync_acc_in = {sync_acc_ff[15:8], req_header_byte};
               phase_in    = PH_CODE_BYTE;
            end
            PH_CODE_BYTE: begin
               code_byte_in = req_header_byte;
               phase_in     = PH_DEPTH;
            end
            PH_DEPTH: begin
               depth_byte_in = req_header_byte;
               phase_in      = PH_NUM_FIRST;
            end
            PH_NUM_FIRST: begin
               // 10xxxxxx is taken as a whole one-byte number, 0xFF as 0xFE
               if (req_header_byte < 8'hC0) begin
                  number_acc_in = INDEX_W'(req_header_byte);
                  bytes_left_in = LEFT_W'(0);
               end else if (req_header_byte[7:5] == 3'b110) begin
                  number_acc_in = INDEX_W'(req_header_byte[4:0]);
                  bytes_left_in = LEFT_W'(1);
               end else if (req_header_byte[7:4] == 4'b1110) begin
                  number_acc_in = INDEX_W'(req_header_byte[3:0]);
                  bytes_left_in = LEFT_W'(2);
               end else if (req_header_byte[7:3] == 5'b11110) begin
                  number_acc_in = INDEX_W'(req_header_byte[2:0]);
                  bytes_left_in = LEFT_W'(3);
               end else if (req_header_byte[7:2] == 6'b111110) begin
                  number_acc_in = INDEX_W'(req_header_byte[1:0]);
                  bytes_left_in = LEFT_W'(4);
               end else if (req_header_byte[7:1] == 7'b1111110) begin
                  number_acc_in = INDEX_W'(req_header_byte[0]);
                  bytes_left_in = LEFT_W'(5);
               end else begin
                  number_acc_in = '0;
                  bytes_left_in = LEFT_W'(6);
               end
               if (bytes_left_in == '0) begin
                  phase_in      = size_phase;
                  bytes_left_in = size_left;
               end else begin
                  phase_in = PH_NUM_CONT;
               end
            end
            PH_NUM_CONT: begin
               number_acc_in = {number_acc_ff[INDEX_W-7:0], req_header_byte[5:0]};
               bytes_left_in = left_dec;
               if (left_dec == '0) begin
                  phase_in      = size_phase;
                  bytes_left_in = size_left;
               end
            end
            PH_EXTRA_SIZE: begin
               extra_size_in = {extra_size_ff[7:0], req_header_byte};
               bytes_left_in = left_dec;
               if (left_dec == '0) begin
                  phase_in      = rate_phase;
                  bytes_left_in = rate_left;
               end
            end
            PH_EXTRA_RATE: begin
               extra_rate_in = {extra_rate_ff[7:0], req_header_byte};
               bytes_left_in = left_dec;
               if (left_dec == '0) begin
                  phase_in = PH_CRC;
               end
            end
            PH_CRC: begin
               phase_in = PH_DONE;
            end
            default: begin
               // done: bytes are dropped until the next frame_start
            end
         endcase
      end
   end

   // header decode into the result register
   always_comb begin
      rsp_status_in = STATUS_OK;

      case (size_code) inside
         BSZ_RESERVED: begin
            rsp_blk_in    = BLK_W'(192);
            rsp_status_in = STATUS_RESERVED_SIZE;
         end
         BSZ_192:                  rsp_blk_in = BLK_W'(192);
         [4'd2:4'd5]:              rsp_blk_in = BLK_W'(144) << size_code;
         BSZ_EXTRA8, BSZ_EXTRA16:  rsp_blk_in = BLK_W'(extra_size_ff) + BLK_W'(1);
         default:                  rsp_blk_in = BLK_W'(256) << size_code[2:0];
      endcase

      case (rate_code) inside
         RATE_STREAM: rsp_rate_in = stream_rate_ff;
         [4'd1:4'd11]: rsp_rate_in = rate_from_code(rate_code);
         RATE_KHZ8:   rsp_rate_in = RATE_W'(extra_rate_ff[7:0]) * RATE_W'(1000);
         RATE_HZ16:   rsp_rate_in = RATE_W'(extra_rate_ff);
         RATE_DHZ16:  rsp_rate_in = RATE_W'(extra_rate_ff) * RATE_W'(10);
         default: begin
            rsp_rate_in = '0;
            if (rsp_status_in == STATUS_OK) begin
               rsp_status_in = STATUS_BAD_RATE;
            end
         end
      endcase

      rsp_depth_in = (depth_code == DEPTH_STREAM) ? stream_depth_ff
                                                  : depth_from_code(depth_code);

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_rate_ff  <= STREAM_RATE_RST;
         stream_depth_ff <= STREAM_DEPTH_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STREAM_RATE:  stream_rate_ff  <= csr_wdata;
            CSR_STREAM_DEPTH: stream_depth_ff <= csr_wdata[DEPTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SYNC0;
         sync_acc_ff   <= '0;
         code_byte_ff  <= '0;
         depth_byte_ff <= '0;
         number_acc_ff <= '0;
         bytes_left_ff <= '0;
         extra_size_ff <= '0;
         extra_rate_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         sync_acc_ff   <= sync_acc_in;
         code_byte_ff  <= code_byte_in;
         depth_byte_ff <= depth_byte_in;
         number_acc_ff <= number_acc_in;
         bytes_left_ff <= bytes_left_in;
         extra_size_ff <= extra_size_in;
         extra_rate_ff <= extra_rate_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload, loaded with the CRC byte
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_sync_ff   <= sync_acc_ff;
         rsp_blk_ff    <= rsp_blk_in;
         rsp_rate_ff   <= rsp_rate_in;
         rsp_depth_ff  <= rsp_depth_in;
         rsp_chan_ff   <= depth_byte_ff[7:4];
         rsp_index_ff  <= number_acc_ff;
         rsp_crc_ff    <= req_header_byte;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sync_code    = rsp_sync_ff;
   assign rsp_block_length = rsp_blk_ff;
   assign rsp_rate_hz      = rsp_rate_ff;
   assign rsp_sample_depth = rsp_depth_ff;
   assign rsp_channel_code = rsp_chan_ff;
   assign rsp_frame_index  = rsp_index_ff;
   assign rsp_header_crc   = rsp_crc_ff;
   assign rsp_status       = rsp_status_ff;

   assign counted_phase  = phase_ff inside {PH_NUM_CONT, PH_EXTRA_SIZE, PH_EXTRA_RATE};
   assign size_has_extra = size_code inside {BSZ_EXTRA8, BSZ_EXTRA16};

   // a header never loads over an untaken result
   `FFHP_ASSERT(a_no_overwrite, !rsp_load || !rsp_valid_ff || rsp_ready, "result overwritten")

   // loading a result always closes the frame
   `FFHP_ASSERT_NEXT(a_load_done, rsp_load, rsp_valid_ff && phase_ff == PH_DONE, "CRC not closed")

   // counted phases always have bytes outstanding
   `FFHP_ASSERT(a_left_nonzero, !counted_phase || bytes_left_ff != '0, "no bytes left")

   // the extra-size phase is only entered for codes 6 and 7
   `FFHP_ASSERT(a_extra_size_code, phase_ff != PH_EXTRA_SIZE || size_has_extra, "bad size code")

endmodule
